>>> src/gbr_pkg.sv
// Shared constants and types of the 3x3 Gaussian blur block.
package gbr_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int CHANNEL_BITS_DEF = 8;

    localparam int ROW_W        = 12;
    localparam int COL_OUT_W    = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Position of a pixel inside the window, oldest row or column first.
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_OLD = 2'd0;
    localparam t_slot SLOT_MID = 2'd1;
    localparam t_slot SLOT_NEW = 2'd2;

    // Window slots that feed the kernel taps, index 0 is the upper or left tap.
    typedef struct packed {
        t_slot [2:0] row;
        t_slot [2:0] col;
    } t_taps;

endpackage

>>> src/gauss_blur_3x3_rgb.sv
// Top level of the streaming 3x3 Gaussian blur for RGB pixels with clamp-to-edge borders.
//
//   Channel   Direction  Fields (lowest bit first)
//   s_axis    in         tdata: pix_red, pix_green, pix_blue
//   m_axis    out        tdata: out_red, out_green, out_blue, out_row, out_col;
//                        tlast: last_of_run; tuser: frame_done
//   cfg       in         index 0 frame_width, index 1 frame_height
//
// One pixel is taken per clock unless a stage ahead holds; a pixel that closes a row or the
// frame causes up to four results, which leave one per clock through the output register
// unless it stalls, while the input waits. A pixel's results pass the line buffer and emit
// stages and the output register. The line buffer is one memory port pair, read registered.
// Reset is synchronous and clears position counters and pipeline valids, not the line buffer.
// A stalled output holds a pixel with results in the emit stage; then at most two pixels wait.
module gauss_blur_3x3_rgb #(
    parameter int MAX_WIDTH    = gbr_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = gbr_pkg::CHANNEL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pix_red, pix_green, pix_blue, zero pad
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_red, out_green, out_blue, out_row, out_col, zero pad
    output logic [((3*CHANNEL_BITS+22+7)/8)*8-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    // frame_done
    output logic [0:0]                       m_axis_tuser,
    input  logic                             i_cfg_wr_en,
    input  logic [0:0]                       i_cfg_addr,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data
);

    localparam int PIX_W     = 3 * CHANNEL_BITS;
    localparam int OUT_RAW_W = PIX_W + gbr_pkg::ROW_W + gbr_pkg::COL_OUT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W     = gbr_pkg::ROW_W;
    localparam int RESET_LAST_COL = (gbr_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                    MAX_WIDTH - 1 : gbr_pkg::WIDTH_RESET - 1;
    localparam int RESET_LAST_ROW = gbr_pkg::HEIGHT_RESET - 1;

    // ---------------- configuration ----------------
    logic [gbr_pkg::WIDTH_REG_W-1:0]  cfg_w;
    logic [gbr_pkg::HEIGHT_REG_W-1:0] cfg_h;
    logic [COL_W-1:0] cfg_last_col;
    logic [ROW_W-1:0] cfg_last_row;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;

    // The frame size is kept as the index of the last column and row, already clamped.
    always_comb begin
        cfg_w = i_cfg_wr_data[gbr_pkg::WIDTH_REG_W-1:0];
        cfg_h = i_cfg_wr_data[gbr_pkg::HEIGHT_REG_W-1:0];
        if (cfg_w == '0) begin
            cfg_last_col = '0;
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            cfg_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = COL_W'(cfg_w - 1'b1);
        end
        if (cfg_h == '0) begin
            cfg_last_row = '0;
        end else if (32'(cfg_h) > gbr_pkg::MAX_HEIGHT) begin
            cfg_last_row = ROW_W'(gbr_pkg::MAX_HEIGHT - 1);
        end else begin
            cfg_last_row = ROW_W'(cfg_h - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= COL_W'(RESET_LAST_COL);
            r_last_row <= ROW_W'(RESET_LAST_ROW);
        end else if (i_cfg_wr_en) begin
            unique case (gbr_pkg::t_cfg_idx'(i_cfg_addr))
                gbr_pkg::CFG_FRAME_WIDTH:  r_last_col <= cfg_last_col;
                gbr_pkg::CFG_FRAME_HEIGHT: r_last_row <= cfg_last_row;
            endcase
        end
    end

    // ---------------- input stage ----------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] row_cur;
    logic col_end, row_end;
    logic in_fire;
    logic [3:0] in_mask;

    // A position left beyond a smaller frame size saturates to the last column or row.
    assign c_cur   = (r_col > r_last_col) ? r_last_col : r_col;
    assign row_cur = (r_row > r_last_row) ? r_last_row : r_row;
    assign col_end = (c_cur == r_last_col);
    assign row_end = (row_cur == r_last_row);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Results in raster order: upper-left, upper-right, lower-left, lower-right.
    assign in_mask = {row_end && col_end, row_end && (c_cur != '0),
                      (row_cur != '0) && col_end, (row_cur != '0) && (c_cur != '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : row_cur + 1'b1;
            end else begin
                r_col <= c_cur + 1'b1;
                r_row <= row_cur;
            end
        end
    end

    // ---------------- line buffer stage ----------------
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic [3:0]       r_s1_mask;
    logic             r_s1_rge2, r_s1_rge1, r_s1_cge2, r_s1_cge1;
    logic             s1_adv;
    logic [2*PIX_W-1:0] line_rd;
    logic [PIX_W-1:0]   line_two, line_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_px   <= s_axis_tdata[PIX_W-1:0];
            r_s1_col  <= c_cur;
            r_s1_row  <= row_cur;
            r_s1_mask <= in_mask;
            r_s1_rge2 <= (row_cur > ROW_W'(1));
            r_s1_rge1 <= (row_cur != '0);
            r_s1_cge2 <= (c_cur > COL_W'(1));
            r_s1_cge1 <= (c_cur != '0);
        end
    end

    // Each entry holds the pixels two rows back (upper half) and one row back.
    gbr_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({line_one, r_s1_px}),
        .i_rd_en   (in_fire),
        .i_rd_addr (c_cur),
        .o_rd_data (line_rd)
    );

    assign line_two = line_rd[2*PIX_W-1:PIX_W];
    assign line_one = line_rd[PIX_W-1:0];

    // ---------------- window cells ----------------
    logic [2:0][2:0][PIX_W-1:0] win;
    logic [2:0][PIX_W-1:0]      new_col;

    assign new_col = {r_s1_px, line_one, line_two};

    for (genvar k = 0; k < 3; k++) begin : g_cell
        logic [2:0][PIX_W-1:0] cell_in;
        if (k == 2) begin : g_head
            assign cell_in = new_col;
        end else begin : g_link
            assign cell_in = win[k+1];
        end
        gbr_col_cell #(
            .PIX_W (PIX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_adv),
            .i_col   (cell_in),
            .o_col   (win[k])
        );
    end

    // ---------------- emit stage ----------------
    logic             r_e_valid;
    logic [3:0]       r_e_mask;
    logic [COL_W-1:0] r_e_col;
    logic [ROW_W-1:0] r_e_row;
    logic             r_e_rge2, r_e_rge1, r_e_cge2, r_e_cge1;
    logic [3:0]       sel_oh, rest;
    logic             e_cur_row, e_cur_col;
    logic             out_load, e_fire, e_done, e_free;
    gbr_pkg::t_taps   taps;
    logic [PIX_W-1:0] blur_px;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    assign sel_oh    = r_e_mask & (~r_e_mask + 4'd1);
    assign rest      = r_e_mask & ~sel_oh;
    assign e_cur_row = sel_oh[3] || sel_oh[2];
    assign e_cur_col = sel_oh[3] || sel_oh[1];

    assign out_load = !m_axis_tvalid || m_axis_tready;
    assign e_fire   = r_e_valid && (r_e_mask != '0) && out_load;
    assign e_done   = r_e_valid && ((r_e_mask == '0) || ((rest == '0) && out_load));
    assign e_free   = !r_e_valid || e_done;
    assign s1_adv   = r_s1_valid && e_free;
    assign s_axis_tready = !r_s1_valid || e_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_mask  <= '0;
        end else if (s1_adv) begin
            r_e_valid <= 1'b1;
            r_e_mask  <= r_s1_mask;
        end else if (e_done) begin
            r_e_valid <= 1'b0;
            r_e_mask  <= '0;
        end else if (e_fire) begin
            r_e_mask  <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_e_col  <= r_s1_col;
            r_e_row  <= r_s1_row;
            r_e_rge2 <= r_s1_rge2;
            r_e_rge1 <= r_s1_rge1;
            r_e_cge2 <= r_s1_cge2;
            r_e_cge1 <= r_s1_cge1;
        end
    end

    // Border clamping reduces to picking a nearer window slot for the outer taps.
    always_comb begin
        if (e_cur_row) begin
            taps.row[0] = r_e_rge1 ? gbr_pkg::SLOT_MID : gbr_pkg::SLOT_NEW;
            taps.row[1] = gbr_pkg::SLOT_NEW;
        end else begin
            taps.row[0] = r_e_rge2 ? gbr_pkg::SLOT_OLD : gbr_pkg::SLOT_MID;
            taps.row[1] = gbr_pkg::SLOT_MID;
        end
        taps.row[2] = gbr_pkg::SLOT_NEW;
        if (e_cur_col) begin
            taps.col[0] = r_e_cge1 ? gbr_pkg::SLOT_MID : gbr_pkg::SLOT_NEW;
            taps.col[1] = gbr_pkg::SLOT_NEW;
        end else begin
            taps.col[0] = r_e_cge2 ? gbr_pkg::SLOT_OLD : gbr_pkg::SLOT_MID;
            taps.col[1] = gbr_pkg::SLOT_MID;
        end
        taps.col[2] = gbr_pkg::SLOT_NEW;
    end

    gbr_kernel #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_kernel (
        .i_win  (win),
        .i_taps (taps),
        .o_pix  (blur_px)
    );

    assign out_row = e_cur_row ? r_e_row : r_e_row - 1'b1;
    assign out_col = e_cur_col ? r_e_col : r_e_col - 1'b1;

    // ---------------- output register ----------------
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_data;
    logic             r_o_last;
    logic             r_o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= e_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_o_data <= OUT_W'({gbr_pkg::COL_OUT_W'(out_col), out_row, blur_px});
            r_o_last <= (rest == '0);
            r_o_done <= sel_oh[3];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_done;

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("frame end result is not the last of its run");

    a_done_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[PIX_W +: ROW_W] == r_last_row) &&
            (m_axis_tdata[PIX_W+ROW_W +: gbr_pkg::COL_OUT_W] ==
             gbr_pkg::COL_OUT_W'(r_last_col)))
        else $error("frame end flagged away from the bottom-right pixel");

    a_line_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> $stable(line_rd))
        else $error("line buffer read data changed under a stalled transaction");

    a_no_early_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_e_valid |-> ($countones(r_e_mask) <= 1))
        else $error("window shifted while results of the previous pixel were pending");
`endif

endmodule

>>> src/gbr_line_buf.sv
// Line buffer memory with a registered, write-first read port.
module gbr_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read of the address being written in the same cycle returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/gbr_col_cell.sv
// One window column cell: holds three pixels and passes them to its neighbor on a shift.
module gbr_col_cell #(
    parameter int PIX_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [2:0][PIX_W-1:0] i_col,
    output logic [2:0][PIX_W-1:0] o_col
);

    logic [2:0][PIX_W-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

>>> src/gbr_kernel.sv
// 1-2-1 by 1-2-1 kernel over the selected window taps, result divided by 16.
module gbr_kernel #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [2:0][2:0][3*CHANNEL_BITS-1:0] i_win,
    input  gbr_pkg::t_taps                      i_taps,
    output logic [3*CHANNEL_BITS-1:0]           o_pix
);

    localparam int PIX_W = 3 * CHANNEL_BITS;
    localparam int SUM_W = CHANNEL_BITS + 4;

    // tap_px[dc][dr] with the window slot resolved for the clamped border.
    logic [2:0][2:0][PIX_W-1:0] tap_px;

    always_comb begin
        for (int dc = 0; dc < 3; dc++) begin
            for (int dr = 0; dr < 3; dr++) begin
                tap_px[dc][dr] = i_win[i_taps.col[dc]][i_taps.row[dr]];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [SUM_W-1:0] sum;

        always_comb begin
            sum = '0;
            for (int dc = 0; dc < 3; dc++) begin
                for (int dr = 0; dr < 3; dr++) begin
                    sum = sum + (SUM_W'(tap_px[dc][dr][k*CHANNEL_BITS +: CHANNEL_BITS])
                                 << (int'(dc == 1) + int'(dr == 1)));
                end
            end
        end

        assign o_pix[k*CHANNEL_BITS +: CHANNEL_BITS] = sum[SUM_W-1:4];
    end

endmodule
